/* hdl/lfu_pkg.sv */
// Package for the LFU key/value store: sizes, widths and the
// command/status structs shared by controller and datapath. No dependencies.
`default_nettype none
package lfu_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILL_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W    = 5;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 32;
  localparam int STAMP_W  = 64;
  localparam int ADDR_W   = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);
  localparam logic              MODE_GET = 1'b0;
  localparam logic              MODE_PUT = 1'b1;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

/* hdl/lfu_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on lfu_pkg for field widths.
`default_nettype none
interface lfu_req_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [lfu_pkg::KEY_W-1:0]  key;
  logic [lfu_pkg::DATA_W-1:0] value;
  modport source (output valid, output mode, output key, output value, input ready);
  modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lfu_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lfu_pkg::DATA_W-1:0] read_value;
  modport source (output valid, output hit, output read_value, input ready);
  modport sink (input valid, input hit, input read_value, output ready);
endinterface
`default_nettype wire

/* hdl/lfu_ctrl.sv */
// Request sequencer: accept, scan of all entries, commit.
// Depends on lfu_pkg.
`default_nettype none
module lfu_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire lfu_pkg::status_t st,
  output lfu_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (st.scan_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/lfu_dp.sv */
// Datapath: entry storage, match/victim/free-slot scan, update and output register.
// Depends on lfu_pkg.
`default_nettype none
module lfu_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lfu_pkg::cmd_t              cmd,
  output lfu_pkg::status_t                st,
  input  wire logic                       req_mode,
  input  wire logic [lfu_pkg::KEY_W-1:0]  req_key,
  input  wire logic [lfu_pkg::DATA_W-1:0] req_value,
  input  wire logic [lfu_pkg::CAP_W-1:0]  capacity,
  output logic                            rsp_valid,
  input  wire logic                       rsp_ready,
  output logic                            rsp_hit,
  output logic [lfu_pkg::DATA_W-1:0]      rsp_read_value
);

  localparam int N = lfu_pkg::ENTRIES;

  logic [N-1:0]                 slot_valid;
  logic [lfu_pkg::KEY_W-1:0]    slot_key   [N];
  logic [lfu_pkg::DATA_W-1:0]   slot_data  [N];
  logic [lfu_pkg::CNT_W-1:0]    use_count  [N];
  logic [lfu_pkg::STAMP_W-1:0]  touch_stamp[N];
  logic [lfu_pkg::STAMP_W-1:0]  stamp_clock;
  logic [lfu_pkg::FILL_W-1:0]   fill_count;

  logic                         op_mode;
  logic [lfu_pkg::KEY_W-1:0]    op_key;
  logic [lfu_pkg::DATA_W-1:0]   op_value;
  logic [lfu_pkg::IDX_W-1:0]    scan_idx;

  logic                         found;
  logic [lfu_pkg::IDX_W-1:0]    at_idx;
  logic [lfu_pkg::DATA_W-1:0]   at_data;
  logic [lfu_pkg::CNT_W-1:0]    at_cnt;
  logic                         have;
  logic [lfu_pkg::IDX_W-1:0]    best_idx;
  logic [lfu_pkg::CNT_W-1:0]    best_cnt;
  logic [lfu_pkg::STAMP_W-1:0]  best_stamp;
  logic                         free_have;
  logic [lfu_pkg::IDX_W-1:0]    free_idx;

  logic                         rd_valid;
  logic [lfu_pkg::KEY_W-1:0]    rd_key;
  logic [lfu_pkg::CNT_W-1:0]    rd_cnt;
  logic [lfu_pkg::STAMP_W-1:0]  rd_stamp;
  logic                         is_match;
  logic                         is_better;

  logic [lfu_pkg::FILL_W-1:0]   eff_cap;
  logic                         evict;
  logic [lfu_pkg::IDX_W-1:0]    new_idx;
  logic [lfu_pkg::FILL_W-1:0]   fill_next;

  assign rd_valid = slot_valid[scan_idx];
  assign rd_key   = slot_key[scan_idx];
  assign rd_cnt   = use_count[scan_idx];
  assign rd_stamp = touch_stamp[scan_idx];

  assign is_match  = rd_valid && (rd_key == op_key) && !found;
  assign is_better = rd_valid && (!have || (rd_cnt < best_cnt) ||
                     ((rd_cnt == best_cnt) && (rd_stamp < best_stamp)));

  assign st.scan_last = (scan_idx == lfu_pkg::IDX_W'(N - 1));
  assign st.out_busy  = rsp_valid && !rsp_ready;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = lfu_pkg::FILL_W'(1);
    end else if ({1'b0, capacity} > 6'(N)) begin
      eff_cap = lfu_pkg::FILL_W'(N);
    end else begin
      eff_cap = lfu_pkg::FILL_W'(capacity);
    end
  end

  assign evict = (fill_count >= eff_cap);

  always_comb begin
    if (evict) begin
      new_idx   = have ? best_idx : '0;
      fill_next = have ? fill_count : lfu_pkg::FILL_W'(1);
    end else begin
      new_idx   = free_have ? free_idx : '0;
      fill_next = fill_count + lfu_pkg::FILL_W'(1);
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode   <= req_mode;
      op_key    <= req_key;
      op_value  <= req_value;
      scan_idx  <= '0;
      found     <= 1'b0;
      have      <= 1'b0;
      free_have <= 1'b0;
    end else if (cmd.step) begin
      if (!st.scan_last) begin
        scan_idx <= scan_idx + lfu_pkg::IDX_W'(1);
      end
      if (is_match) begin
        found   <= 1'b1;
        at_idx  <= scan_idx;
        at_data <= slot_data[scan_idx];
        at_cnt  <= rd_cnt;
      end
      if (is_better) begin
        have       <= 1'b1;
        best_idx   <= scan_idx;
        best_cnt   <= rd_cnt;
        best_stamp <= rd_stamp;
      end
      if (!rd_valid && !free_have) begin
        free_have <= 1'b1;
        free_idx  <= scan_idx;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (found) begin
        if (at_cnt != '1) begin
          use_count[at_idx] <= at_cnt + lfu_pkg::CNT_W'(1);
        end
        touch_stamp[at_idx] <= stamp_clock;
        if (op_mode == lfu_pkg::MODE_PUT) begin
          slot_data[at_idx] <= op_value;
        end
      end else if (op_mode == lfu_pkg::MODE_PUT) begin
        slot_key[new_idx]    <= op_key;
        slot_data[new_idx]   <= op_value;
        use_count[new_idx]   <= '0;
        touch_stamp[new_idx] <= stamp_clock;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      stamp_clock <= '0;
      fill_count  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (found || (op_mode == lfu_pkg::MODE_PUT)) begin
          stamp_clock <= stamp_clock + lfu_pkg::STAMP_W'(1);
        end
        if (!found && (op_mode == lfu_pkg::MODE_PUT)) begin
          slot_valid[new_idx] <= 1'b1;
          fill_count          <= fill_next;
        end
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_hit <= found;
      if (op_mode == lfu_pkg::MODE_PUT) begin
        rsp_read_value <= '0;
      end else if (found) begin
        rsp_read_value <= at_data;
      end else begin
        rsp_read_value <= lfu_pkg::MISS_VALUE;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/lfu_cache_replacement.sv */
// LFU cache with LRU tie break: each request goes through accept, a scan of
// all 16 entries, and commit; one request in flight at a time.
// Response appears in the output register on the cycle after commit.
// Synchronous reset clears all entries' valid bits, stamp clock and fill;
// capacity resets to 16. No clearing pass is needed.
// Depends on lfu_pkg, lfu_if, lfu_ctrl, lfu_dp.
`default_nettype none
module lfu_cache_replacement (
  input  wire logic                        clk,
  input  wire logic                        rst,
  lfu_req_if.sink                          req,
  lfu_rsp_if.source                        rsp,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lfu_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [lfu_pkg::PDATA_W-1:0] pwdata,
  output logic [lfu_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  lfu_pkg::cmd_t             cmd;
  lfu_pkg::status_t          st;
  logic [lfu_pkg::CAP_W-1:0] capacity;
  logic                      cap_sel;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[lfu_pkg::ADDR_W-1:2] == lfu_pkg::ADDR_CAPACITY[lfu_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfu_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      capacity <= pwdata[lfu_pkg::CAP_W-1:0];
    end
  end

  assign prdata = cap_sel ? {{(lfu_pkg::PDATA_W - lfu_pkg::CAP_W){1'b0}}, capacity} : '0;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  lfu_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .req_mode       (req.mode),
    .req_key        (req.key),
    .req_value      (req.value),
    .capacity       (capacity),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_read_value (rsp.read_value)
  );

endmodule
`default_nettype wire

/* hdl/lfu_checker.sv */
// Port-level checks for lfu_cache_replacement, bound to the top level.
// Depends on lfu_pkg.
`default_nettype none
module lfu_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [lfu_pkg::DATA_W-1:0]  rsp_read_value,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [lfu_pkg::ADDR_W-1:0]  paddr,
  input wire logic [lfu_pkg::PDATA_W-1:0] pwdata,
  input wire logic [lfu_pkg::PDATA_W-1:0] prdata
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
    else $error("stalled response changed");

  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  a_rsp_after_req: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response without a request in flight");

  a_cap_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr == lfu_pkg::ADDR_CAPACITY) |=>
    prdata[lfu_pkg::CAP_W-1:0] == $past(pwdata[lfu_pkg::CAP_W-1:0]) || paddr != $past(paddr))
    else $error("capacity write not taken");

endmodule

bind lfu_cache_replacement lfu_checker u_lfu_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_read_value (rsp.read_value),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
`default_nettype wire
